[hdl/otq_pkg.sv]
// ----------------------------------------------------------------------------
// otq_pkg
// Shared types and constants for the ordered timer queue.
// ----------------------------------------------------------------------------
package otq_pkg;

  localparam int unsigned NumTimers = 32;
  localparam int unsigned SlotW     = $clog2(NumTimers);
  localparam int unsigned MaxExpire = 64;
  localparam int unsigned CntW      = $clog2(MaxExpire + 1);

  localparam logic [30:0] NsPerS    = 31'd1000000000;
  localparam logic [30:0] NsPerS2   = 31'd2000000000;

  // operation codes
  typedef logic [2:0] func_t;
  localparam func_t FnAddAt       = 3'd0;
  localparam func_t FnAddAfter    = 3'd1;
  localparam func_t FnAddPeriodic = 3'd2;
  localparam func_t FnDelete      = 3'd3;
  localparam func_t FnUpdate      = 3'd4;
  localparam func_t FnTick        = 3'd5;
  localparam func_t FnForce       = 3'd6;

  // result status codes
  typedef logic [2:0] status_t;
  localparam status_t StAdded     = 3'd0;
  localparam status_t StFull      = 3'd1;
  localparam status_t StBadInt    = 3'd2;
  localparam status_t StBadHandle = 3'd3;
  localparam status_t StExpired   = 3'd4;
  localparam status_t StDone      = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_DIV_ADD, S_SCAN, S_EVAL, S_DIV_TICK, S_FINISH, S_RESP
  } state_e;

  typedef struct packed {
    status_t     status;
    logic [4:0]  slot;
    logic [31:0] tag;
    logic        last;
  } res_t;

  // time entry: expiry and insertion position
  typedef struct packed {
    logic [31:0] s;
    logic [29:0] ns;
    logic [31:0] ord;
  } tent_t;

  // attribute entry: period and user tag
  typedef struct packed {
    logic [31:0] per;
    logic [31:0] tag;
  } aent_t;

endpackage

[hdl/otq_div.sv]
// ----------------------------------------------------------------------------
// otq_div
// Restoring divider, one quotient bit per cycle; yields the remainder.
// ----------------------------------------------------------------------------
module otq_div
  import otq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] num_q, num_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] trial;

  // one restoring step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, num_q[32]};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[31:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = 32'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[31:0];
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[hdl/otq_core.sv]
// ----------------------------------------------------------------------------
// otq_core
// Timer table in two memories, sequential scan for the earliest timer and
// the operation sequencer.
// ----------------------------------------------------------------------------
module otq_core
  import otq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  func_t            func_i,
  input  logic [31:0]      time_s_i,
  input  logic [29:0]      time_ns_i,
  input  logic [31:0]      period_s_i,
  input  logic [31:0]      tag_i,
  input  logic [SlotW-1:0] slot_i,
  output logic             push_valid_o,
  output res_t             push_res_o,
  input  logic             push_ready_i
);

  // memories
  tent_t tmem [NumTimers];
  aent_t amem [NumTimers];
  tent_t trd_q;
  aent_t ard_q;

  state_e state_q, state_d;
  func_t  fn_q, fn_d;
  logic [31:0] ts_q, ts_d;
  logic [29:0] tns_q, tns_d;
  logic [31:0] per_q, per_d;
  logic [31:0] tag_q, tag_d;
  logic [NumTimers-1:0] valid_q, valid_d;
  logic [31:0] order_q, order_d;
  logic [31:0] last_s_q, last_s_d;
  logic [29:0] last_ns_q, last_ns_d;
  logic [31:0] add_s_q, add_s_d;
  logic [29:0] add_ns_q, add_ns_d;
  logic [SlotW:0]   scan_q, scan_d;
  logic             rd_v_q, rd_v_d;
  logic [SlotW-1:0] rd_idx_q, rd_idx_d;
  logic             best_v_q, best_v_d;
  logic [SlotW-1:0] best_idx_q, best_idx_d;
  tent_t            best_t_q, best_t_d;
  aent_t            best_a_q, best_a_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pend_v_q, pend_v_d;
  res_t             pend_q, pend_d;
  res_t             res_q, res_d;

  logic             tw_en, aw_en;
  logic [SlotW-1:0] w_addr;
  tent_t            tw_data;
  aent_t            aw_data;
  logic             rd_en;
  logic [SlotW-1:0] rd_addr;

  logic             div_start, div_busy, div_done;
  logic [32:0]      div_num;
  logic [31:0]      div_den, div_rem;

  logic             have_free;
  logic [SlotW-1:0] free_idx;
  logic [30:0]      ns_sum;
  logic [31:0]      after_s;
  logic [29:0]      after_ns;
  logic             is_before, due, emit;
  logic [32:0]      realign_num;
  logic [CntW-1:0]  cnt_inc;

  otq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // lowest free slot
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        have_free = 1'b1;
        free_idx  = SlotW'(i);
      end
    end
  end

  // offset add with nanosecond carry
  always_comb begin
    ns_sum = {1'b0, last_ns_q} + {1'b0, tns_q};
    if (ns_sum >= NsPerS2) begin
      after_ns = 30'(ns_sum - NsPerS2);
      after_s  = last_s_q + ts_q + 32'd2;
    end else if (ns_sum >= NsPerS) begin
      after_ns = 30'(ns_sum - NsPerS);
      after_s  = last_s_q + ts_q + 32'd1;
    end else begin
      after_ns = ns_sum[29:0];
      after_s  = last_s_q + ts_q;
    end
  end

  // ordering of the entry just read against the best so far
  always_comb begin
    if (trd_q.s != best_t_q.s) begin
      is_before = trd_q.s < best_t_q.s;
    end else if (trd_q.ns != best_t_q.ns) begin
      is_before = trd_q.ns < best_t_q.ns;
    end else begin
      is_before = trd_q.ord < best_t_q.ord;
    end
  end

  assign due = (best_t_q.s < ts_q) || ((best_t_q.s == ts_q) && (best_t_q.ns <= tns_q));
  assign emit        = (best_a_q.per == 32'd0) || (best_t_q.s > best_a_q.per);
  assign realign_num = {1'b0, ts_q} + {1'b0, best_a_q.per} - 33'd1;
  assign cnt_inc     = cnt_q + CntW'(1);

  // sequencer
  always_comb begin
    state_d    = state_q;
    fn_d       = fn_q;
    ts_d       = ts_q;
    tns_d      = tns_q;
    per_d      = per_q;
    tag_d      = tag_q;
    valid_d    = valid_q;
    order_d    = order_q;
    last_s_d   = last_s_q;
    last_ns_d  = last_ns_q;
    add_s_d    = add_s_q;
    add_ns_d   = add_ns_q;
    scan_d     = scan_q;
    rd_v_d     = 1'b0;
    rd_idx_d   = rd_idx_q;
    best_v_d   = best_v_q;
    best_idx_d = best_idx_q;
    best_t_d   = best_t_q;
    best_a_d   = best_a_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    res_d      = res_q;
    tw_en      = 1'b0;
    aw_en      = 1'b0;
    w_addr     = best_idx_q;
    tw_data    = '{s: best_t_q.s, ns: best_t_q.ns, ord: order_q};
    aw_data    = '{per: per_q, tag: tag_q};
    rd_en      = 1'b0;
    rd_addr    = scan_q[SlotW-1:0];
    div_start  = 1'b0;
    div_num    = {1'b0, last_s_q};
    div_den    = per_q;
    in_ready_o = 1'b0;
    push_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          fn_d   = func_i;
          ts_d   = time_s_i;
          tns_d  = time_ns_i;
          per_d  = period_s_i;
          tag_d  = tag_i;
          res_d  = '{status: StDone, slot: '0, tag: '0, last: 1'b1};
          scan_d = '0;
          best_v_d = 1'b0;
          state_d  = S_RESP;
          if (func_i == FnAddAt || func_i == FnAddAfter) begin
            per_d   = '0;
            state_d = S_ADD;
          end else if (func_i == FnAddPeriodic) begin
            if (period_s_i == 32'd0) begin
              res_d.status = StBadInt;
            end else begin
              div_start = 1'b1;
              div_den   = period_s_i;
              state_d   = S_DIV_ADD;
            end
          end else if (func_i == FnDelete || func_i == FnUpdate) begin
            if (!valid_q[slot_i]) begin
              res_d.status = StBadHandle;
            end else begin
              res_d.slot = 5'(slot_i);
              if (func_i == FnDelete) begin
                valid_d[slot_i] = 1'b0;
              end else begin
                tw_en   = 1'b1;
                w_addr  = slot_i;
                tw_data = '{s: time_s_i, ns: time_ns_i, ord: order_q};
                order_d = order_q + 32'd1;
              end
            end
          end else if (func_i == FnTick) begin
            if (time_s_i != last_s_q || time_ns_i != last_ns_q) begin
              last_s_d  = time_s_i;
              last_ns_d = time_ns_i;
              cnt_d     = '0;
              pend_v_d  = 1'b0;
              state_d   = S_SCAN;
            end
          end else if (func_i == FnForce) begin
            state_d = S_SCAN;
          end
        end
      end

      S_DIV_ADD: begin
        if (div_done) begin
          add_s_d  = last_s_q - div_rem + per_q;
          add_ns_d = '0;
          state_d  = S_ADD;
        end
      end

      S_ADD: begin
        state_d = S_RESP;
        if (!have_free) begin
          res_d = '{status: StFull, slot: '0, tag: '0, last: 1'b1};
        end else begin
          tw_en   = 1'b1;
          aw_en   = 1'b1;
          w_addr  = free_idx;
          valid_d[free_idx] = 1'b1;
          order_d = order_q + 32'd1;
          if (fn_q == FnAddAt) begin
            tw_data = '{s: ts_q, ns: tns_q, ord: order_q};
          end else if (fn_q == FnAddAfter) begin
            tw_data = '{s: after_s, ns: after_ns, ord: order_q};
          end else begin
            tw_data = '{s: add_s_q, ns: add_ns_q, ord: order_q};
          end
          res_d = '{status: StAdded, slot: 5'(free_idx), tag: '0, last: 1'b1};
        end
      end

      S_SCAN: begin
        // issue reads in slot order, compare in the next cycle
        if (!scan_q[SlotW]) begin
          rd_en    = 1'b1;
          rd_v_d   = 1'b1;
          rd_idx_d = scan_q[SlotW-1:0];
          scan_d   = scan_q + (SlotW + 1)'(1);
        end
        if (rd_v_q && valid_q[rd_idx_q] && (!best_v_q || is_before)) begin
          best_v_d   = 1'b1;
          best_idx_d = rd_idx_q;
          best_t_d   = trd_q;
          best_a_d   = ard_q;
        end
        if (scan_q[SlotW] && !rd_v_q) begin
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        if (fn_q == FnForce) begin
          state_d = S_RESP;
          if (best_v_q) begin
            valid_d[best_idx_q] = 1'b0;
            res_d = '{status: StExpired, slot: 5'(best_idx_q), tag: best_a_q.tag,
                      last: 1'b1};
          end
        end else if (!best_v_q || !due) begin
          state_d = S_FINISH;
        end else if (!(emit && pend_v_q && !push_ready_i)) begin
          // hand the held expiry on once the next one is known
          if (emit && pend_v_q) begin
            push_valid_o = 1'b1;
          end
          if (emit) begin
            pend_v_d = 1'b1;
            pend_d   = '{status: StExpired, slot: 5'(best_idx_q), tag: best_a_q.tag,
                         last: 1'b0};
          end
          cnt_d    = cnt_inc;
          scan_d   = '0;
          best_v_d = 1'b0;
          state_d  = (cnt_inc == CntW'(MaxExpire)) ? S_FINISH : S_SCAN;
          if (best_a_q.per == 32'd0) begin
            valid_d[best_idx_q] = 1'b0;
          end else if (best_t_q.s > best_a_q.per) begin
            tw_en   = 1'b1;
            tw_data = '{s: best_t_q.s + best_a_q.per, ns: best_t_q.ns, ord: order_q};
            order_d = order_q + 32'd1;
          end else begin
            div_start = 1'b1;
            div_num   = realign_num;
            div_den   = best_a_q.per;
            best_v_d  = best_v_q;
            state_d   = S_DIV_TICK;
          end
        end
      end

      S_DIV_TICK: begin
        if (div_done) begin
          tw_en    = 1'b1;
          tw_data  = '{s: 32'(realign_num - {1'b0, div_rem}), ns: best_t_q.ns,
                       ord: order_q};
          order_d  = order_q + 32'd1;
          best_v_d = 1'b0;
          state_d  = (cnt_q == CntW'(MaxExpire)) ? S_FINISH : S_SCAN;
        end
      end

      S_FINISH: begin
        if (pend_v_q) begin
          res_d      = pend_q;
          res_d.last = 1'b1;
        end else begin
          res_d = '{status: StDone, slot: '0, tag: '0, last: 1'b1};
        end
        pend_v_d = 1'b0;
        state_d  = S_RESP;
      end

      S_RESP: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign push_res_o = (state_q == S_EVAL) ? pend_q : res_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      order_q   <= '0;
      last_s_q  <= '0;
      last_ns_q <= '0;
      scan_q    <= '0;
      rd_v_q    <= 1'b0;
      best_v_q  <= 1'b0;
      cnt_q     <= '0;
      pend_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      order_q   <= order_d;
      last_s_q  <= last_s_d;
      last_ns_q <= last_ns_d;
      scan_q    <= scan_d;
      rd_v_q    <= rd_v_d;
      best_v_q  <= best_v_d;
      cnt_q     <= cnt_d;
      pend_v_q  <= pend_v_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    fn_q       <= fn_d;
    ts_q       <= ts_d;
    tns_q      <= tns_d;
    per_q      <= per_d;
    tag_q      <= tag_d;
    add_s_q    <= add_s_d;
    add_ns_q   <= add_ns_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_t_q   <= best_t_d;
    best_a_q   <= best_a_d;
    pend_q     <= pend_d;
    res_q      <= res_d;
  end

  // table memories, registered read port
  always_ff @(posedge clk_i) begin
    if (tw_en) begin
      tmem[w_addr] <= tw_data;
    end
    if (aw_en) begin
      amem[w_addr] <= aw_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      trd_q <= tmem[rd_addr];
      ard_q <= amem[rd_addr];
    end
  end

  // checks
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_push_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && push_valid_o) |-> push_ready_i)
    else $error("held expiry pushed into a full output stage");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxExpire)) else $error("expiry count beyond cap");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !tw_en && !aw_en) else $error("table write during scan");

endmodule

[hdl/ordered_timer_queue.sv]
// ----------------------------------------------------------------------------
// ordered_timer_queue
// Timer table ordered by expiry with ties in insertion order.
// ----------------------------------------------------------------------------
// One operation is taken at a time. A periodic add uses the shared remainder
// divider. A tick or force-expire scans the whole 32-entry table through the
// memory read port and then evaluates the earliest entry. A tick does one scan
// per due timer (with a divider run when a periodic timer is realigned) and,
// unless the cap of 64 expiries per tick is reached, one final scan. Results
// leave through an output register, so the next operation is taken while the
// last result waits.
module ordered_timer_queue
  import otq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // time_s[31:0], time_ns[61:32], period_s[93:62], tag[125:94], slot[130:126]
  input  logic [135:0] s_axis_tdata_i,
  // func
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_slot[4:0], out_tag[36:5]
  output logic [39:0]  m_axis_tdata_o,
  // status
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  logic out_v_q, out_v_d;
  res_t out_q;
  logic push_valid, push_ready;
  res_t push_res;

  otq_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .func_i       (s_axis_tuser_i),
    .time_s_i     (s_axis_tdata_i[31:0]),
    .time_ns_i    (s_axis_tdata_i[61:32]),
    .period_s_i   (s_axis_tdata_i[93:62]),
    .tag_i        (s_axis_tdata_i[125:94]),
    .slot_i       (s_axis_tdata_i[130:126]),
    .push_valid_o (push_valid),
    .push_res_o   (push_res),
    .push_ready_i (push_ready)
  );

  // output register
  assign push_ready = !out_v_q || m_axis_tready_i;

  always_comb begin
    out_v_d = out_v_q;
    if (push_ready) begin
      out_v_d = push_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ready && push_valid) begin
      out_q <= push_res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {3'b000, out_q.tag, out_q.slot};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;

endmodule
